[rtl/gram_schmidt_orthonormalize3_core_defines.svh]
// Assertion macros for the three-vector orthonormalizer checker
`ifndef GRAM_SCHMIDT_ORTHONORMALIZE3_CORE_DEFINES_SVH
`define GRAM_SCHMIDT_ORTHONORMALIZE3_CORE_DEFINES_SVH

// Property checked outside reset.
`define GSO3_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define GSO3_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/gso3_pkg.sv]
// Types, constants and arithmetic helpers shared by the orthonormalizer
package gso3_pkg;

    localparam int W          = 24;
    localparam int FRAC_BITS  = 16;
    localparam int TOL_W      = 16;
    localparam int SQ_W       = 2 * W;
    localparam int NUM_W      = W + FRAC_BITS;
    localparam int PROD_W     = 2 * W;
    localparam int ACC_W      = 2 * W + 2;
    localparam int ISQ_STEPS  = W;
    localparam int DIV_STAGES = W + 1;
    localparam int NORM_LAT   = ISQ_STEPS + DIV_STAGES + 4;

    typedef logic signed [W-1:0]      t_word;
    typedef t_word [2:0]              t_vec3;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [PROD_W-1:0] t_prod;

    localparam t_acc  WORD_MAX = ACC_W'((1 <<< (W - 1)) - 1);
    localparam t_acc  WORD_MIN = -WORD_MAX - ACC_W'(1);
    localparam t_acc  RND_HALF = ACC_W'(1 <<< (FRAC_BITS - 1));
    localparam t_word UNIT_ONE = W'(1 <<< FRAC_BITS);

    typedef struct packed {
        t_word v0_x;
        t_word v0_y;
        t_word v0_z;
        t_word v1_x;
        t_word v1_y;
        t_word v1_z;
        t_word v2_x;
        t_word v2_y;
        t_word v2_z;
    } t_in_item;

    typedef struct packed {
        t_word u0_x;
        t_word u0_y;
        t_word u0_z;
        t_word u1_x;
        t_word u1_y;
        t_word u1_z;
        t_word u2_x;
        t_word u2_y;
        t_word u2_z;
        logic  degenerate_first;
        logic  degenerate_second;
        logic  degenerate_third;
    } t_out_item;

    function automatic t_word sat_word(input t_acc v);
        t_acc r;
        if (v > WORD_MAX) begin
            r = WORD_MAX;
        end else if (v < WORD_MIN) begin
            r = WORD_MIN;
        end else begin
            r = v;
        end
        return r[W-1:0];
    endfunction

    // Drop the fraction bits, round to nearest with ties away from zero.
    function automatic t_acc round_frac(input t_acc v);
        t_acc b;
        b = v[ACC_W-1] ? (RND_HALF - ACC_W'(1)) : RND_HALF;
        return (v + b) >>> FRAC_BITS;
    endfunction

endpackage

[rtl/gram_schmidt_orthonormalize3_core.sv]
// Top level: Gram-Schmidt orthonormalization of three Q8.16 vectors
//
//   channel  | valid       | ready        | payload
//   ---------+-------------+--------------+-----------------------------
//   input    | i_in_valid  | o_in_ready   | i_in_item  (t_in_item)
//   result   | o_out_valid | i_out_ready  | o_out_item (t_out_item)
//   config   | i_cfg_valid | o_cfg_ready  | i_cfg_data (length_tolerance)
//
// One item per cycle while no result waits at the output; the three normalizers
// sit in series (square root and divide at one bit per stage).
// Reset clears every stage valid and the tolerance; payload is not reset.
// A result held at the output freezes the whole pipeline; nothing is lost.
module gram_schmidt_orthonormalize3_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  gso3_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output gso3_pkg::t_out_item          o_out_item,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [gso3_pkg::TOL_W-1:0]   i_cfg_data
);
    import gso3_pkg::*;

    localparam int P_STAGES = 6;

    typedef struct packed {
        t_vec3 v1;
        t_vec3 v2;
    } t_sb0;

    typedef struct packed {
        t_vec3 u0;
        logic  f0;
        t_vec3 v1;
        t_vec3 v2;
    } t_pctx;

    typedef struct packed {
        t_vec3            u0;
        logic             f0;
        t_vec3            v2;
        t_acc [2:0]       tb;
    } t_sb1;

    typedef struct packed {
        t_vec3            u0;
        logic             f0;
        t_vec3            u1;
        logic             f1;
        t_vec3            v2;
        t_acc [2:0]       tb;
    } t_qctx;

    typedef struct packed {
        t_vec3 u0;
        logic  f0;
        t_vec3 u1;
        logic  f1;
    } t_sb2;

    logic [TOL_W-1:0] r_tol;
    logic             w_en;

    t_vec3 w_v0;
    t_sb0  w_sb0_in;
    t_sb0  r_sb0 [NORM_LAT];

    logic  w_n0_valid, w_n0_degen;
    t_vec3 w_n0_vec;

    // first projection stages
    logic [P_STAGES-1:0] r_p_valid;
    t_pctx r_p_ctx [P_STAGES];
    t_prod r_p1_pa [3];
    t_prod r_p1_pb [3];
    t_acc  r_p2_sa, r_p2_sb;
    t_word r_p3_da, r_p3_db;
    t_prod r_p4_pa [3];
    t_prod r_p4_pb [3];
    t_acc  r_p5_ta [3];
    t_acc  r_p5_tb [3];
    t_vec3 r_p6_r1;
    t_acc  r_p6_tb [3];

    t_sb1  w_sb1_in;
    t_sb1  r_sb1 [NORM_LAT];

    logic  w_n1_valid, w_n1_degen;
    t_vec3 w_n1_vec;

    // second projection stages
    logic [P_STAGES-1:0] r_q_valid;
    t_qctx r_q_ctx [P_STAGES];
    t_prod r_q1_p [3];
    t_acc  r_q2_s;
    t_word r_q3_d;
    t_prod r_q4_p [3];
    t_acc  r_q5_t [3];
    t_vec3 r_q6_r2;

    t_sb2  w_sb2_in;
    t_sb2  r_sb2 [NORM_LAT];

    logic  w_n2_valid, w_n2_degen;
    t_vec3 w_n2_vec;

    logic      r_out_valid;
    t_out_item r_out_item;

    // whole pipeline moves unless a result waits at the output
    assign w_en        = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    assign w_v0[0] = i_in_item.v0_x;
    assign w_v0[1] = i_in_item.v0_y;
    assign w_v0[2] = i_in_item.v0_z;

    always_comb begin
        w_sb0_in.v1[0] = i_in_item.v1_x;
        w_sb0_in.v1[1] = i_in_item.v1_y;
        w_sb0_in.v1[2] = i_in_item.v1_z;
        w_sb0_in.v2[0] = i_in_item.v2_x;
        w_sb0_in.v2[1] = i_in_item.v2_y;
        w_sb0_in.v2[2] = i_in_item.v2_z;
    end

    gso3_norm u_norm0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_vec   (w_v0),
        .i_tol   (r_tol),
        .o_valid (w_n0_valid),
        .o_vec   (w_n0_vec),
        .o_degen (w_n0_degen)
    );

    always_comb begin
        w_sb1_in.u0 = r_p_ctx[P_STAGES-1].u0;
        w_sb1_in.f0 = r_p_ctx[P_STAGES-1].f0;
        w_sb1_in.v2 = r_p_ctx[P_STAGES-1].v2;
        for (int i = 0; i < 3; i++) begin
            w_sb1_in.tb[i] = r_p6_tb[i];
        end
    end

    gso3_norm u_norm1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p_valid[P_STAGES-1]),
        .i_vec   (r_p6_r1),
        .i_tol   (r_tol),
        .o_valid (w_n1_valid),
        .o_vec   (w_n1_vec),
        .o_degen (w_n1_degen)
    );

    always_comb begin
        w_sb2_in.u0 = r_q_ctx[P_STAGES-1].u0;
        w_sb2_in.f0 = r_q_ctx[P_STAGES-1].f0;
        w_sb2_in.u1 = r_q_ctx[P_STAGES-1].u1;
        w_sb2_in.f1 = r_q_ctx[P_STAGES-1].f1;
    end

    gso3_norm u_norm2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_q_valid[P_STAGES-1]),
        .i_vec   (r_q6_r2),
        .i_tol   (r_tol),
        .o_valid (w_n2_valid),
        .o_vec   (w_n2_vec),
        .o_degen (w_n2_degen)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= '0;
            r_q_valid   <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid   <= {r_p_valid[P_STAGES-2:0], w_n0_valid};
            r_q_valid   <= {r_q_valid[P_STAGES-2:0], w_n1_valid};
            r_out_valid <= w_n2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // side data rides alongside each normalizer
            r_sb0[0] <= w_sb0_in;
            r_sb1[0] <= w_sb1_in;
            r_sb2[0] <= w_sb2_in;
            for (int k = 1; k < NORM_LAT; k++) begin
                r_sb0[k] <= r_sb0[k-1];
                r_sb1[k] <= r_sb1[k-1];
                r_sb2[k] <= r_sb2[k-1];
            end

            // u0 . v1 and u0 . v2, then subtract the u0 part from v1
            r_p_ctx[0].u0 <= w_n0_vec;
            r_p_ctx[0].f0 <= w_n0_degen;
            r_p_ctx[0].v1 <= r_sb0[NORM_LAT-1].v1;
            r_p_ctx[0].v2 <= r_sb0[NORM_LAT-1].v2;
            for (int k = 1; k < P_STAGES; k++) begin
                r_p_ctx[k] <= r_p_ctx[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                r_p1_pa[i] <= $signed(w_n0_vec[i]) * $signed(r_sb0[NORM_LAT-1].v1[i]);
                r_p1_pb[i] <= $signed(w_n0_vec[i]) * $signed(r_sb0[NORM_LAT-1].v2[i]);
            end
            r_p2_sa <= ACC_W'(r_p1_pa[0]) + ACC_W'(r_p1_pa[1]) + ACC_W'(r_p1_pa[2]);
            r_p2_sb <= ACC_W'(r_p1_pb[0]) + ACC_W'(r_p1_pb[1]) + ACC_W'(r_p1_pb[2]);
            r_p3_da <= sat_word(round_frac(r_p2_sa));
            r_p3_db <= sat_word(round_frac(r_p2_sb));
            for (int i = 0; i < 3; i++) begin
                r_p4_pa[i] <= r_p3_da * $signed(r_p_ctx[2].u0[i]);
                r_p4_pb[i] <= r_p3_db * $signed(r_p_ctx[2].u0[i]);
                r_p5_ta[i] <= round_frac(ACC_W'(r_p4_pa[i]));
                r_p5_tb[i] <= round_frac(ACC_W'(r_p4_pb[i]));
                r_p6_r1[i] <= sat_word(ACC_W'($signed(r_p_ctx[4].v1[i])) - r_p5_ta[i]);
                r_p6_tb[i] <= r_p5_tb[i];
            end

            // u1 . v2, then subtract both parts from v2
            r_q_ctx[0].u0 <= r_sb1[NORM_LAT-1].u0;
            r_q_ctx[0].f0 <= r_sb1[NORM_LAT-1].f0;
            r_q_ctx[0].u1 <= w_n1_vec;
            r_q_ctx[0].f1 <= w_n1_degen;
            r_q_ctx[0].v2 <= r_sb1[NORM_LAT-1].v2;
            r_q_ctx[0].tb <= r_sb1[NORM_LAT-1].tb;
            for (int k = 1; k < P_STAGES; k++) begin
                r_q_ctx[k] <= r_q_ctx[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                r_q1_p[i] <= $signed(w_n1_vec[i]) * $signed(r_sb1[NORM_LAT-1].v2[i]);
            end
            r_q2_s <= ACC_W'(r_q1_p[0]) + ACC_W'(r_q1_p[1]) + ACC_W'(r_q1_p[2]);
            r_q3_d <= sat_word(round_frac(r_q2_s));
            for (int i = 0; i < 3; i++) begin
                r_q4_p[i]  <= r_q3_d * $signed(r_q_ctx[2].u1[i]);
                r_q5_t[i]  <= round_frac(ACC_W'(r_q4_p[i]));
                r_q6_r2[i] <= sat_word(ACC_W'($signed(r_q_ctx[4].v2[i]))
                                       - $signed(r_q_ctx[4].tb[i]) - r_q5_t[i]);
            end

            // output register
            r_out_item.u0_x              <= r_sb2[NORM_LAT-1].u0[0];
            r_out_item.u0_y              <= r_sb2[NORM_LAT-1].u0[1];
            r_out_item.u0_z              <= r_sb2[NORM_LAT-1].u0[2];
            r_out_item.u1_x              <= r_sb2[NORM_LAT-1].u1[0];
            r_out_item.u1_y              <= r_sb2[NORM_LAT-1].u1[1];
            r_out_item.u1_z              <= r_sb2[NORM_LAT-1].u1[2];
            r_out_item.u2_x              <= w_n2_vec[0];
            r_out_item.u2_y              <= w_n2_vec[1];
            r_out_item.u2_z              <= w_n2_vec[2];
            r_out_item.degenerate_first  <= r_sb2[NORM_LAT-1].f0;
            r_out_item.degenerate_second <= r_sb2[NORM_LAT-1].f1;
            r_out_item.degenerate_third  <= w_n2_degen;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[rtl/gso3_norm.sv]
// Pipelined vector normalizer: sum of squares, bit-serial square root, divide per component
module gso3_norm (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  gso3_pkg::t_vec3              i_vec,
    input  logic [gso3_pkg::TOL_W-1:0]   i_tol,
    output logic                         o_valid,
    output gso3_pkg::t_vec3              o_vec,
    output logic                         o_degen
);
    import gso3_pkg::*;

    // squares
    logic              r_a_valid;
    t_vec3             r_a_vec;
    logic [W-1:0]      r_a_mag [3];
    logic [SQ_W-1:0]   r_a_sq [3];
    logic [W-1:0]      n_a_mag [3];

    // sum
    logic              r_b_valid;
    t_vec3             r_b_vec;
    logic [W-1:0]      r_b_mag [3];
    logic [SQ_W-1:0]   r_b_n;

    // square root, one result bit per stage
    logic [ISQ_STEPS-1:0] r_s_valid;
    t_vec3             r_s_vec [ISQ_STEPS];
    logic [W-1:0]      r_s_mag [ISQ_STEPS][3];
    logic [SQ_W-1:0]   r_s_n   [ISQ_STEPS];
    logic [SQ_W-1:0]   r_s_res [ISQ_STEPS];
    logic [SQ_W-1:0]   w_s_in_n   [ISQ_STEPS];
    logic [SQ_W-1:0]   w_s_in_res [ISQ_STEPS];
    logic [SQ_W-1:0]   w_s_bit    [ISQ_STEPS];
    logic [SQ_W-1:0]   w_s_trial  [ISQ_STEPS];
    logic [SQ_W-1:0]   n_s_n   [ISQ_STEPS];
    logic [SQ_W-1:0]   n_s_res [ISQ_STEPS];

    // length, tolerance, numerators
    logic              r_c_valid;
    t_vec3             r_c_vec;
    logic [W-1:0]      r_c_len;
    logic              r_c_degen;
    logic [NUM_W-1:0]  r_c_num [3];
    logic [W-1:0]      w_len;

    // division: stage 0 checks overflow, then one quotient bit per stage
    logic [DIV_STAGES-1:0] r_d_valid;
    t_vec3             r_d_vec   [DIV_STAGES];
    logic [W-1:0]      r_d_len   [DIV_STAGES];
    logic              r_d_degen [DIV_STAGES];
    logic [W-1:0]      r_d_rem   [DIV_STAGES][3];
    logic [W-1:0]      r_d_q     [DIV_STAGES][3];
    logic [W-1:0]      r_d_lo    [DIV_STAGES][3];
    logic              r_d_ovf   [DIV_STAGES][3];
    logic [W-1:0]      n_d_rem   [DIV_STAGES][3];
    logic [W-1:0]      n_d_q     [DIV_STAGES][3];
    logic [W:0]        w_d_ext   [DIV_STAGES][3];
    logic              w_d_ge    [DIV_STAGES][3];

    // sign and saturation
    logic              r_e_valid;
    t_vec3             r_e_vec;
    logic              r_e_degen;
    t_vec3             n_e_vec;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_mag[i] = i_vec[i][W-1] ? W'(-i_vec[i]) : W'(i_vec[i]);
        end
    end

    always_comb begin
        w_s_in_n[0]   = r_b_n;
        w_s_in_res[0] = '0;
        for (int k = 1; k < ISQ_STEPS; k++) begin
            w_s_in_n[k]   = r_s_n[k-1];
            w_s_in_res[k] = r_s_res[k-1];
        end
        for (int k = 0; k < ISQ_STEPS; k++) begin
            w_s_bit[k]   = SQ_W'(1) << (2 * (W - 1 - k));
            w_s_trial[k] = w_s_in_res[k] + w_s_bit[k];
            if (w_s_in_n[k] >= w_s_trial[k]) begin
                n_s_n[k]   = w_s_in_n[k] - w_s_trial[k];
                n_s_res[k] = (w_s_in_res[k] >> 1) + w_s_bit[k];
            end else begin
                n_s_n[k]   = w_s_in_n[k];
                n_s_res[k] = w_s_in_res[k] >> 1;
            end
        end
    end

    assign w_len = r_s_res[ISQ_STEPS-1][W-1:0];

    always_comb begin
        for (int j = 0; j < DIV_STAGES; j++) begin
            for (int i = 0; i < 3; i++) begin
                w_d_ext[j][i] = '0;
                w_d_ge[j][i]  = 1'b0;
                n_d_rem[j][i] = '0;
                n_d_q[j][i]   = '0;
            end
        end
        for (int i = 0; i < 3; i++) begin
            n_d_rem[0][i] = W'(r_c_num[i][NUM_W-1:W]);
        end
        for (int j = 1; j < DIV_STAGES; j++) begin
            for (int i = 0; i < 3; i++) begin
                w_d_ext[j][i] = {r_d_rem[j-1][i], r_d_lo[j-1][i][W-1]};
                w_d_ge[j][i]  = w_d_ext[j][i] >= {1'b0, r_d_len[j-1]};
                n_d_rem[j][i] = w_d_ge[j][i] ? W'(w_d_ext[j][i] - {1'b0, r_d_len[j-1]})
                                             : w_d_ext[j][i][W-1:0];
                n_d_q[j][i]   = {r_d_q[j-1][i][W-2:0], w_d_ge[j][i]};
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_d_degen[DIV_STAGES-1]) begin
                n_e_vec[i] = r_d_vec[DIV_STAGES-1][i];
            end else if (!r_d_vec[DIV_STAGES-1][i][W-1]) begin
                if (r_d_ovf[DIV_STAGES-1][i] || r_d_q[DIV_STAGES-1][i][W-1]) begin
                    n_e_vec[i] = WORD_MAX[W-1:0];
                end else begin
                    n_e_vec[i] = r_d_q[DIV_STAGES-1][i];
                end
            end else begin
                if (r_d_ovf[DIV_STAGES-1][i] || (r_d_q[DIV_STAGES-1][i][W-1]
                        && |r_d_q[DIV_STAGES-1][i][W-2:0])) begin
                    n_e_vec[i] = WORD_MIN[W-1:0];
                end else begin
                    n_e_vec[i] = -r_d_q[DIV_STAGES-1][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_s_valid <= '0;
            r_c_valid <= 1'b0;
            r_d_valid <= '0;
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_s_valid <= {r_s_valid[ISQ_STEPS-2:0], r_b_valid};
            r_c_valid <= r_s_valid[ISQ_STEPS-1];
            r_d_valid <= {r_d_valid[DIV_STAGES-2:0], r_c_valid};
            r_e_valid <= r_d_valid[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_vec <= i_vec;
            for (int i = 0; i < 3; i++) begin
                r_a_mag[i] <= n_a_mag[i];
                r_a_sq[i]  <= SQ_W'(n_a_mag[i]) * SQ_W'(n_a_mag[i]);
            end

            r_b_vec <= r_a_vec;
            r_b_mag <= r_a_mag;
            r_b_n   <= r_a_sq[0] + r_a_sq[1] + r_a_sq[2];

            r_s_vec[0] <= r_b_vec;
            r_s_mag[0] <= r_b_mag;
            for (int k = 1; k < ISQ_STEPS; k++) begin
                r_s_vec[k] <= r_s_vec[k-1];
                r_s_mag[k] <= r_s_mag[k-1];
            end
            r_s_n   <= n_s_n;
            r_s_res <= n_s_res;

            r_c_vec   <= r_s_vec[ISQ_STEPS-1];
            r_c_len   <= w_len;
            r_c_degen <= w_len <= W'(i_tol);
            for (int i = 0; i < 3; i++) begin
                r_c_num[i] <= {r_s_mag[ISQ_STEPS-1][i], FRAC_BITS'(0)}
                              + NUM_W'(w_len >> 1);
            end

            r_d_vec[0]   <= r_c_vec;
            r_d_len[0]   <= r_c_len;
            r_d_degen[0] <= r_c_degen;
            for (int i = 0; i < 3; i++) begin
                r_d_rem[0][i] <= n_d_rem[0][i];
                r_d_q[0][i]   <= '0;
                r_d_lo[0][i]  <= r_c_num[i][W-1:0];
                r_d_ovf[0][i] <= n_d_rem[0][i] >= r_c_len;
            end
            for (int j = 1; j < DIV_STAGES; j++) begin
                r_d_vec[j]   <= r_d_vec[j-1];
                r_d_len[j]   <= r_d_len[j-1];
                r_d_degen[j] <= r_d_degen[j-1];
                for (int i = 0; i < 3; i++) begin
                    r_d_rem[j][i] <= n_d_rem[j][i];
                    r_d_q[j][i]   <= n_d_q[j][i];
                    r_d_lo[j][i]  <= r_d_lo[j-1][i] << 1;
                    r_d_ovf[j][i] <= r_d_ovf[j-1][i];
                end
            end

            r_e_vec   <= n_e_vec;
            r_e_degen <= r_d_degen[DIV_STAGES-1];
        end
    end

    assign o_valid = r_e_valid;
    assign o_vec   = r_e_vec;
    assign o_degen = r_e_degen;

endmodule

[rtl/gso3_checker.sv]
// Port-level checker for the orthonormalizer, bound to the top level
`include "gram_schmidt_orthonormalize3_core_defines.svh"

module gso3_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input gso3_pkg::t_out_item o_out_item
);
    import gso3_pkg::*;

    `GSO3_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid,
        "output valid after reset")

    `GSO3_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item),
        "stalled item changed")

    `GSO3_ASSERT(a_ready_follows_output, i_clk, i_rst_n,
        o_in_ready == (!o_out_valid || i_out_ready),
        "input ready does not track output stall")

    `GSO3_ASSERT(a_u0_unit, i_clk, i_rst_n,
        o_out_valid && !o_out_item.degenerate_first |->
            o_out_item.u0_x <= UNIT_ONE && o_out_item.u0_x >= -UNIT_ONE,
        "normalized u0 above one")

    `GSO3_ASSERT(a_u2_unit, i_clk, i_rst_n,
        o_out_valid && !o_out_item.degenerate_third |->
            o_out_item.u2_z <= UNIT_ONE && o_out_item.u2_z >= -UNIT_ONE,
        "normalized u2 above one")

endmodule

bind gram_schmidt_orthonormalize3_core gso3_checker u_gso3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
